// File: rtl/ssc_pkg.sv
// Shared types, constants and helpers for the shell sort block.
// No dependencies; every other file of the block but ssc_ram uses this package.
package ssc_pkg;

  localparam int WORD_W = 16;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t COUNT_MAX = '1;

  // Saturating increment for the operation counters.
  function automatic word_t sat_inc(input word_t c);
    word_t r;
    r = (c == COUNT_MAX) ? COUNT_MAX : c + word_t'(1);
    return r;
  endfunction

endpackage

// File: rtl/ssc_if.sv
// Valid/ready channel interfaces for the shell sort block.
// Depends on ssc_pkg for the payload word type.
interface ssc_in_if;
  logic          valid;
  logic          ready;
  ssc_pkg::word_t value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface ssc_out_if;
  logic          valid;
  logic          ready;
  ssc_pkg::word_t sorted_value;
  logic          last;
  ssc_pkg::word_t comparison_count;
  ssc_pkg::word_t move_count;

  modport source(output valid, output sorted_value, output last,
                 output comparison_count, output move_count, input ready);
  modport sink(input valid, input sorted_value, input last,
               input comparison_count, input move_count, output ready);
endinterface

// File: rtl/ssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ssc_front.sv
// Front end: accepts input beats and tags each with its batch index and last flag.
// Depends on ssc_pkg and ssc_in_if.
module ssc_front #(
  parameter int NUM_ELEMENTS = 32,
  parameter int VALUE_WIDTH  = 16,
  parameter int AW           = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ssc_in_if.sink                   in_ch,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [VALUE_WIDTH+AW:0]  q_data
);
  import ssc_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ELEMENTS - 1);

  logic [AW-1:0]          cnt_r, cnt_nxt;
  logic                   is_last;
  logic [VALUE_WIDTH-1:0] value_k;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign is_last     = (cnt_r == LAST_IDX);
  assign value_k     = VALUE_WIDTH'(in_ch.value);
  assign q_data      = {is_last, cnt_r, value_k};

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = is_last ? '0 : cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/ssc_queue.sv
// Short FIFO between the front end and the sort engine.
// Depends on ssc_pkg only by house convention; holds opaque tagged beats.
module ssc_queue #(
  parameter int WIDTH = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import ssc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r, count_nxt;

  assign full  = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH)) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (PW'(count_r) == PW'(wr_ptr_r - rd_ptr_r))) else $error("queue pointers disagree");
`endif

endmodule

// File: rtl/ssc_back.sv
// Sort engine: loads tagged beats into the store, runs the gapped insertion
// passes, then streams the sorted run. Depends on ssc_pkg, ssc_out_if, ssc_ram.
module ssc_back #(
  parameter int NUM_ELEMENTS = 32,
  parameter int VALUE_WIDTH  = 16,
  parameter int AW           = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    gap_mode,
  input  logic                    q_empty,
  input  logic [VALUE_WIDTH+AW:0] q_data,
  output logic                    q_pop,
  ssc_out_if.source               out_ch
);
  import ssc_pkg::*;

  localparam int CW = $clog2(NUM_ELEMENTS + 1);
  localparam logic [CW-1:0] N_C     = CW'(NUM_ELEMENTS);
  localparam logic [CW-1:0] LAST_C  = CW'(NUM_ELEMENTS - 1);
  localparam int G2 = (NUM_ELEMENTS / 2 < 1) ? 1 : NUM_ELEMENTS / 2;
  localparam int G3 = (NUM_ELEMENTS / 3 < 1) ? 1 : NUM_ELEMENTS / 3;
  localparam logic [CW-1:0] GAP2_C  = CW'(G2);
  localparam logic [CW-1:0] GAP3_C  = CW'(G3);

  typedef enum logic [8:0] {
    ST_LOAD      = 9'b000000001,
    ST_START     = 9'b000000010,
    ST_READ_I    = 9'b000000100,
    ST_HELD      = 9'b000001000,
    ST_CMP       = 9'b000010000,
    ST_PUT       = 9'b000100000,
    ST_EMIT_RD   = 9'b001000000,
    ST_EMIT_CAP  = 9'b010000000,
    ST_EMIT_WAIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]          i_r, i_nxt, k_r, k_nxt, gap_r, gap_nxt, j_r, j_nxt;
  logic [VALUE_WIDTH-1:0] held_r, held_nxt, val_r, val_nxt;
  logic                   last_r, last_nxt, out_valid_r, out_valid_nxt;
  word_t                  cmp_r, cmp_nxt, mov_r, mov_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   q_last;
  logic [AW-1:0]          q_idx;
  logic [VALUE_WIDTH-1:0] q_value;

  logic [CW-1:0] gap_div, gap_next, k_sh;
  logic [CW+3:0] gap_x11;

  assign {q_last, q_idx, q_value} = q_data;

  // gap / 3 as (gap * 11) >> 5, exact for gap below 32
  assign gap_x11  = (CW+4)'(gap_r) * (CW+4)'(11);
  assign gap_div  = gap_mode ? CW'(gap_x11 >> 5) : (gap_r >> 1);
  // a gap that would fall from above one straight to zero becomes one
  assign gap_next = (gap_div == '0 && gap_r > CW'(1)) ? CW'(1) : gap_div;
  assign k_sh     = k_r - gap_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    gap_nxt       = gap_r;
    j_nxt         = j_r;
    held_nxt      = held_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmp_nxt       = cmp_r;
    mov_nxt       = mov_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = AW'(k_r);
    ram_wdata     = held_r;
    ram_raddr     = AW'(i_r);

    unique case (state_r)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = q_idx;
          ram_wdata = q_value;
          // first beat of a batch clears the counters
          if (q_idx == '0) begin
            cmp_nxt = '0;
            mov_nxt = '0;
          end
          if (q_last) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        gap_nxt   = gap_mode ? GAP3_C : GAP2_C;
        i_nxt     = gap_mode ? GAP3_C : GAP2_C;
        state_nxt = ST_READ_I;
      end
      ST_READ_I: begin
        if (i_r == N_C) begin
          // end of pass: advance the gap, or finish
          gap_nxt = gap_next;
          i_nxt   = gap_next;
          if (gap_next == '0) begin
            j_nxt     = '0;
            state_nxt = ST_EMIT_RD;
          end
        end else begin
          ram_raddr = AW'(i_r);
          state_nxt = ST_HELD;
        end
      end
      ST_HELD: begin
        held_nxt  = ram_rdata;
        k_nxt     = i_r;
        mov_nxt   = sat_inc(mov_r);
        ram_raddr = AW'(i_r - gap_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (ram_rdata > held_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(k_r);
          ram_wdata = ram_rdata;
          cmp_nxt   = sat_inc(cmp_r);
          mov_nxt   = sat_inc(mov_r);
          k_nxt     = k_sh;
          ram_raddr = AW'(k_sh - gap_r);
          state_nxt = (k_sh >= gap_r) ? ST_CMP : ST_PUT;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(k_r);
          ram_wdata = held_r;
          mov_nxt   = sat_inc(mov_r);
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_READ_I;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(k_r);
        ram_wdata = held_r;
        mov_nxt   = sat_inc(mov_r);
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_READ_I;
      end
      ST_EMIT_RD: begin
        ram_raddr = AW'(j_r);
        state_nxt = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        val_nxt       = ram_rdata;
        last_nxt      = (j_r == LAST_C);
        out_valid_nxt = 1'b1;
        j_nxt         = j_r + CW'(1);
        state_nxt     = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = ST_LOAD;
          end else begin
            ram_raddr = AW'(j_r);
            state_nxt = ST_EMIT_CAP;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  ssc_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(NUM_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      i_r         <= '0;
      gap_r       <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      cmp_r       <= '0;
      mov_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      gap_r       <= gap_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_r       <= cmp_nxt;
      mov_r       <= mov_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.sorted_value     = WORD_W'(val_r);
  assign out_ch.last             = last_r;
  assign out_ch.comparison_count = cmp_r;
  assign out_ch.move_count       = mov_r;

`ifndef ASSERT_OFF
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EMIT_WAIT)) else $error("result shown outside emit");
  a_gap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HELD || state_r == ST_CMP || state_r == ST_PUT)
      |-> (gap_r != '0)) else $error("zero gap during a pass");
  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (k_r >= gap_r && k_r < N_C)) else $error("shift index out of range");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_LOAD)) else $error("queue popped while sorting");
  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_WAIT && state_nxt == ST_EMIT_CAP) |=> $stable(cmp_r) && $stable(mov_r))
    else $error("counters moved during emit");
`endif

endmodule

// File: rtl/shell_sort_with_counts.sv
// Shell sort with operation counters. Loads NUM_ELEMENTS values through a 4-entry queue
// at one per cycle while the queue holds a beat, then sorts in place: each visited element
// is read, held and compared, with one more compare per shift, plus a pass turnover, a
// start and a fetch of the first result; results then leave as out_ch.ready allows.
// Reset (rst_n, synchronous, active low) clears control, counters and gap_mode;
// store contents stay undefined until loaded, so no clearing pass runs.
module shell_sort_with_counts #(
  parameter int NUM_ELEMENTS = 32,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ssc_in_if.sink    in_ch,
  ssc_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import ssc_pkg::*;

  localparam int AW = $clog2(NUM_ELEMENTS);
  localparam int QW = VALUE_WIDTH + AW + 1;

  logic          gap_mode_r;
  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_mode_r <= 1'b0;
    end else if (cfg_we) begin
      gap_mode_r <= cfg_wdata;
    end
  end

  ssc_front #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  ssc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  ssc_back #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .gap_mode(gap_mode_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: dv/tb_shell_sort_with_counts.sv
// Testbench for shell_sort_with_counts: loads batches of values, predicts the sorted run
// and both saturating counters in a scoreboard class, and checks every output beat.
// Depends on ssc_pkg, ssc_if (ssc_in_if, ssc_out_if) and the block itself.
`timescale 1ns / 1ps

module tb_shell_sort_with_counts;
  import ssc_pkg::*;

  localparam int NUM_VALUES   = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 700;
  localparam int QUIET_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    word_t sorted_value;
    logic  last;
    word_t comparison_count;
    word_t move_count;
  } sorted_beat_t;

  class sort_scoreboard;
    word_t        store [NUM_VALUES];
    int unsigned  fill = 0;
    word_t        shift_cnt = '0;
    word_t        move_cnt = '0;
    bit           gap_mode = 1'b0;
    sorted_beat_t sorted_q[$];
    int unsigned  mismatches = 0;

    function word_t count_up(input word_t c);
      return (c == '1) ? c : c + word_t'(1);
    endfunction

    function int shrink_gap(input int gap);
      int g;
      g = gap / (gap_mode ? 3 : 2);
      // never skip the final gap-one pass
      if (g == 0 && gap > 1) g = 1;
      return g;
    endfunction

    function void shell_sort_store();
      int    gap;
      int    i;
      int    k;
      word_t held;
      gap = gap_mode ? NUM_VALUES / 3 : NUM_VALUES / 2;
      if (gap < 1) gap = 1;
      while (gap > 0) begin
        for (i = gap; i < NUM_VALUES; i++) begin
          held = store[i];
          k = i;
          move_cnt = count_up(move_cnt);
          while (k >= gap && store[k - gap] > held) begin
            store[k] = store[k - gap];
            k -= gap;
            shift_cnt = count_up(shift_cnt);
            move_cnt = count_up(move_cnt);
          end
          store[k] = held;
          move_cnt = count_up(move_cnt);
        end
        gap = shrink_gap(gap);
      end
    endfunction

    function void note_value(input word_t v);
      sorted_beat_t b;
      if (fill == 0) begin
        shift_cnt = '0;
        move_cnt = '0;
      end
      store[fill] = v;
      fill++;
      if (fill == NUM_VALUES) begin
        fill = 0;
        shell_sort_store();
        for (int k = 0; k < NUM_VALUES; k++) begin
          b.sorted_value = store[k];
          b.last = (k == NUM_VALUES - 1);
          b.comparison_count = shift_cnt;
          b.move_count = move_cnt;
          sorted_q.push_back(b);
        end
      end
    endfunction

    function void check_beat(input sorted_beat_t got);
      sorted_beat_t want;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected beat value=%h last=%b cmp=%0d mov=%0d", $realtime,
                   got.sorted_value, got.last, got.comparison_count, got.move_count);
        return;
      end
      want = sorted_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch exp %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                   $realtime, want.sorted_value, want.last, want.comparison_count,
                   want.move_count, got.sorted_value, got.last, got.comparison_count,
                   got.move_count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ssc_in_if  in_if ();
  ssc_out_if out_if ();

  sort_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_left = 0;
  int unsigned    cycle_cnt = 0;

  shell_sort_with_counts #(
    .NUM_ELEMENTS(NUM_VALUES),
    .VALUE_WIDTH (16)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: a long hold-off takes priority over random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_value(in_if.value);
      if (out_if.valid && out_if.ready)
        sb.check_beat('{out_if.sorted_value, out_if.last, out_if.comparison_count,
                        out_if.move_count});
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Enter and leave at a falling edge.
  task automatic send_value(input word_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gap_mode(input bit m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    sb.gap_mode = m;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Change sender and receiver settings on the rising edge, away from the receiver process.
  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned hold);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    hold_left = hold;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.sorted_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_batches(input int batches);
    int    style;
    word_t v;
    for (int b = 0; b < batches; b++) begin
      style = $urandom_range(3);
      for (int i = 0; i < NUM_VALUES; i++) begin
        case (style)
          0: v = word_t'($urandom);
          1: v = word_t'($urandom_range(7));
          2: v = word_t'(i * 2000 + $urandom_range(3000));
          default: v = word_t'(65535 - i * 2000 - $urandom_range(1500));
        endcase
        send_value(v);
      end
    end
  endtask

  initial begin
    sb = new;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reverse order, top value first and zero last, in the reset gap mode
    for (int i = 0; i < NUM_VALUES; i++)
      send_value((i == NUM_VALUES - 1) ? word_t'(0) : word_t'(16'hFFFF - i * 2047));
    drain();

    // walking ones high to low, then alternating all-ones and zero
    write_gap_mode(1'b1);
    for (int i = 0; i < NUM_VALUES; i++)
      send_value((i < 16) ? (word_t'(1) << (15 - i)) : (i[0] ? word_t'('1) : word_t'(0)));
    drain();

    set_idling(0, 0, 0);
    send_random_batches(1);
    drain();

    write_gap_mode(1'b0);
    set_idling(61, 0, 0);
    send_random_batches(2);
    drain();

    write_gap_mode(1'b1);
    set_idling(0, 61, 0);
    send_random_batches(2);
    drain();

    write_gap_mode(1'b0);
    set_idling(7, 7, 0);
    send_random_batches(2);
    drain();

    // hold the output so the block backs up into its input
    write_gap_mode(1'b1);
    set_idling(0, 0, HOLD_CYCLES);
    send_random_batches(2);
    drain();

    if (sb.mismatches == 0 && sb.sorted_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
